// ===== src/lbps_pkg.sv =====
`timescale 1ns / 1ps

package lbps_pkg;

  // Field widths of the request and result channels
  localparam int LBA_W        = 32;
  localparam int CNT_W        = 8;
  localparam int PNUM_W       = 29;
  localparam int MASK_W       = 8;
  localparam int IN_TDATA_W   = 40;
  localparam int OUT_FIELDS_W = 137;
  localparam int OUT_TDATA_W  = 144;

  // Largest sector count a command may carry
  localparam int MAXCNT_W         = 16;
  localparam int MAX_SECTOR_COUNT = 255;

  // Start-LBA divide by reciprocal multiply: partial products, then sum and shift
  localparam int DIV_CYCLES = 2;
  localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;      // latch a good request
    logic div_step;  // advance the reciprocal multiply of the start LBA
    logic setup;     // form the first page from quotient and remainder
    logic emit;      // load the current page into the output register, advance
    logic emit_err;  // load an error result into the output register
  } ctrl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic in_bad;    // request on the input is rejected
    logic fin;       // current page holds the command end LBA
    logic out_free;  // output register can take a result this cycle
  } dp_stat_t;

endpackage

// ===== src/lbps_ctrl.sv =====
`timescale 1ns / 1ps

module lbps_ctrl
  import lbps_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_SETUP,
    ST_EMIT,
    ST_ERROR
  } state_t;

  state_t               state_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 accept;

  // Take a request only between commands
  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tready && in_tvalid;

  // Decode commands from the current state
  always_comb begin
    cmd          = '0;
    cmd.load     = accept && !stat.in_bad;
    cmd.div_step = (state_r == ST_DIVIDE);
    cmd.setup    = (state_r == ST_SETUP);
    cmd.emit     = (state_r == ST_EMIT) && stat.out_free;
    cmd.emit_err = (state_r == ST_ERROR) && stat.out_free;
  end

  // Hold state and the divider cycle count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          cnt_r <= '0;
          if (accept) begin
            state_r <= stat.in_bad ? ST_ERROR : ST_DIVIDE;
          end
        end
        ST_DIVIDE: begin
          cnt_r <= cnt_r + DIV_CNT_W'(1);
          if (cnt_r == DIV_CNT_W'(DIV_CYCLES - 1)) begin
            state_r <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          state_r <= ST_EMIT;
        end
        ST_EMIT: begin
          if (stat.out_free && stat.fin) begin
            state_r <= ST_IDLE;
          end
        end
        ST_ERROR: begin
          if (stat.out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/lbps_datapath.sv =====
`timescale 1ns / 1ps

module lbps_datapath
  import lbps_pkg::*;
#(
  parameter int SECTORS_PER_PAGE = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ctrl_cmd_t              cmd,
  output dp_stat_t               stat,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tuser,
  output logic                   out_tlast
);

  localparam int REM_W  = $clog2(SECTORS_PER_PAGE);
  localparam int CMP_W  = (REM_W > 3) ? REM_W : 3;
  localparam int PAD_W  = OUT_TDATA_W - OUT_FIELDS_W;
  localparam int HALF_W = LBA_W / 2;
  localparam int PROD_W = HALF_W + LBA_W + 1;
  localparam int FULL_W = 2 * LBA_W + 1;

  localparam logic [LBA_W-1:0]  SPP_L    = LBA_W'(SECTORS_PER_PAGE);
  localparam logic [LBA_W-1:0]  SPP_M1_L = LBA_W'(SECTORS_PER_PAGE - 1);
  localparam logic [REM_W-1:0]  SPP_M1_R = REM_W'(SECTORS_PER_PAGE - 1);
  localparam logic [REM_W-1:0]  SPP_R    = REM_W'(SECTORS_PER_PAGE);
  // ceil(2^(LBA_W+REM_W) / SECTORS_PER_PAGE): exact quotient for any 32-bit LBA
  localparam logic [LBA_W:0]    RECIP_M  = (LBA_W + 1)'(
      ((64'd1 << (LBA_W + REM_W)) + 64'(SECTORS_PER_PAGE - 1)) / 64'(SECTORS_PER_PAGE));

  logic [LBA_W-1:0] in_start;
  logic [CNT_W-1:0] in_count;
  logic [LBA_W:0]   end_sum;

  logic [LBA_W-1:0]  end_r;
  logic [LBA_W-1:0]  req_r;
  logic [LBA_W-1:0]  pstart_r;
  logic [LBA_W-1:0]  page_r;
  logic [LBA_W-1:0]  quo_r;
  logic [PROD_W-1:0] prod_lo_r;
  logic [PROD_W-1:0] prod_hi_r;
  logic [REM_W-1:0]  off_r;
  logic              first_r;

  logic [FULL_W-1:0] prod_sum;
  logic [REM_W-1:0]  rem_v;

  logic [LBA_W-1:0]  diff;
  logic              fin;
  logic [LBA_W-1:0]  pend;
  logic [LBA_W-1:0]  last;
  logic [LBA_W-1:0]  next_lba;
  logic [REM_W-1:0]  hi_off;
  logic              aligned;
  logic [MASK_W-1:0] mask;

  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic                   out_err_r;
  logic                   out_last_r;

  // Unpack the request and check its range
  assign in_start = in_tdata[LBA_W-1:0];
  assign in_count = in_tdata[LBA_W +: CNT_W];
  assign end_sum  = {1'b0, in_start} + (LBA_W + 1)'(in_count) - (LBA_W + 1)'(1);

  assign stat.in_bad = (in_count == '0)
                    || (MAXCNT_W'(in_count) > MAXCNT_W'(MAX_SECTOR_COUNT))
                    || end_sum[LBA_W];

  // Divide the start LBA by the page size: sum the half products, then shift
  assign prod_sum = {prod_hi_r, {HALF_W{1'b0}}} + FULL_W'(prod_lo_r);

  // Remainder only needs its low bits: start minus quotient times page size
  assign rem_v = req_r[REM_W-1:0] - REM_W'(quo_r[REM_W-1:0] * SPP_R);

  // Bounds of the current page
  assign diff     = end_r - pstart_r;
  assign fin      = (diff < SPP_L);
  assign pend     = pstart_r + SPP_M1_L;
  assign last     = fin ? end_r : pend;
  assign next_lba = pstart_r + SPP_L;
  assign hi_off   = fin ? diff[REM_W-1:0] : SPP_M1_R;
  assign aligned  = (off_r == '0) && (hi_off == SPP_M1_R);

  // Merge mask over the covered sector offsets of a partial edge page
  always_comb begin
    for (int b = 0; b < MASK_W; b++) begin
      mask[b] = (CMP_W'(b) >= CMP_W'(off_r)) && (CMP_W'(b) <= CMP_W'(hi_off));
    end
    if (aligned || !(first_r || fin)) begin
      mask = '0;
    end
  end

  assign stat.fin      = fin;
  assign stat.out_free = !out_valid_r || out_tready;

  // Walk state: load, divide, set up the first page, advance page by page
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r   <= in_start;
      end_r   <= end_sum[LBA_W-1:0];
      first_r <= 1'b1;
    end
    if (cmd.div_step) begin
      prod_lo_r <= PROD_W'(req_r[HALF_W-1:0]) * PROD_W'(RECIP_M);
      prod_hi_r <= PROD_W'(req_r[LBA_W-1:HALF_W]) * PROD_W'(RECIP_M);
      quo_r     <= LBA_W'(prod_sum >> (LBA_W + REM_W));
    end
    if (cmd.setup) begin
      page_r   <= quo_r;
      pstart_r <= req_r - LBA_W'(rem_v);
      off_r    <= rem_v;
    end
    if (cmd.emit && !fin) begin
      req_r    <= next_lba;
      pstart_r <= next_lba;
      page_r   <= page_r + LBA_W'(1);
      off_r    <= '0;
      first_r  <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r <= {{PAD_W{1'b0}}, mask, fin, first_r, !aligned, aligned,
                     req_r, last, pstart_r, page_r[PNUM_W-1:0]};
      out_err_r  <= 1'b0;
      out_last_r <= fin;
    end else if (cmd.emit_err) begin
      out_data_r <= '0;
      out_err_r  <= 1'b1;
      out_last_r <= 1'b1;
    end
  end

  // Output register valid: set on load, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit || cmd.emit_err) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_err_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== src/lba_to_logical_page_splitter.sv =====
`timescale 1ns / 1ps

// Splits one host request (start LBA, sector count) into one result per logical
// page of SECTORS_PER_PAGE sectors, in ascending page order, the last one marked
// by out_tlast. Each result carries the page number, page boundary start, last
// covered LBA, first requested LBA, edge-page flags, aligned/merge flags and a
// merge mask of covered sectors for a partial first or last page. A zero count
// or an end LBA past 32 bits gives a single result with out_tuser set and all
// data zero. Steps: a good request is accepted, its start LBA is divided by
// reciprocal multiplication, the first page is set up, and then one page per
// cycle goes through the output register while the result side takes it; a
// rejected request goes from accept straight to its error result. The next
// request is taken as soon as the last result is in the output register.
module lba_to_logical_page_splitter
  import lbps_pkg::*;
#(
  parameter int SECTORS_PER_PAGE = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // start_lba[31:0], sector_count[39:32]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // page_number[28:0], page_first_lba[60:29],
                                             // page_last_lba[92:61], request_lba[124:93],
                                             // aligned[125], merge_needed[126],
                                             // first_page[127], final_page[128],
                                             // sector_mask[136:129], zero[143:137]
  output logic                   out_tuser,  // error_flag
  output logic                   out_tlast   // last_of_run
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  lbps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  lbps_datapath #(
    .SECTORS_PER_PAGE (SECTORS_PER_PAGE)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== src/lbps_checker.sv =====
`timescale 1ns / 1ps

module lbps_checker
  import lbps_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tuser,
  input logic                   out_tlast
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  // Error result is alone and empty
  a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast && (out_tdata == '0))
    else $error("malformed error result");

  // Merge flag is the inverse of aligned on a page result
  a_merge_inv: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[126] != out_tdata[125])
    else $error("merge flag disagrees with aligned");

  // Aligned pages carry no merge mask
  a_mask_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser && out_tdata[125] |-> out_tdata[136:129] == '0)
    else $error("mask set on aligned page");

  // Run ends exactly on the final page
  a_last_fin: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tlast == out_tdata[128])
    else $error("tlast disagrees with final page");

endmodule

bind lba_to_logical_page_splitter lbps_checker u_lbps_checker (.*);
